// ===== hdl/rlepe_pkg.sv =====
// ----------------------------------------------------------------------------
// rlepe_pkg
// Shared types and constants for the run-length pair encoder.
// ----------------------------------------------------------------------------
package rlepe_pkg;

  // Encoded output budget in bytes
  localparam int unsigned BUFFER_BYTES_DEFAULT = 256;

  // Longest run carried by one pair
  localparam logic [7:0] RUN_MAX = 8'd255;

  // Encoded bytes per pair
  localparam logic [9:0] PAIR_BYTES = 10'd2;

  // Largest encoded length the length field can show
  localparam logic [9:0] OUT_CAP = 10'd511;

  // Reset value of the minimum raw length register
  localparam logic [15:0] MIN_RAW_RESET = 16'd64;

  // Raw length saturates here
  localparam logic [15:0] RAW_SAT = 16'hFFFF;

  // Result queue depth and index widths
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One result word
  typedef struct packed {
    logic [7:0] run_length;
    logic [7:0] run_value;
    logic       pair_valid;
    logic       last_result;
    logic [8:0] encoded_length;
    logic       budget_exceeded;
    logic       keep_encoded;
    logic       input_too_long;
  } result_t;

  // Which of the two result slots of one item are pushed
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== hdl/rlepe_queue.sv =====
// ----------------------------------------------------------------------------
// rlepe_queue
// Small result queue: takes up to two words per cycle, hands out one while out_stall is low.
// ----------------------------------------------------------------------------
module rlepe_queue (
  input  logic              clk,
  input  logic              rst,
  input  rlepe_pkg::push_t  push,
  input  rlepe_pkg::result_t res_a,
  input  rlepe_pkg::result_t res_b,
  output logic              space_ok,
  output logic              out_valid,
  input  logic              out_stall,
  output rlepe_pkg::result_t out_word
);

  localparam logic [rlepe_pkg::QUEUE_CNT_W-1:0] SPACE_LIMIT =
    rlepe_pkg::QUEUE_CNT_W'(rlepe_pkg::QUEUE_DEPTH - 2);

  rlepe_pkg::result_t mem [rlepe_pkg::QUEUE_DEPTH];

  logic [rlepe_pkg::QUEUE_IDX_W-1:0] wr_ptr;
  logic [rlepe_pkg::QUEUE_IDX_W-1:0] rd_ptr;
  logic [rlepe_pkg::QUEUE_CNT_W-1:0] count;
  logic [rlepe_pkg::QUEUE_IDX_W-1:0] wr_ptr_plus;
  logic [1:0]                        push_n;
  logic                              pop;
  rlepe_pkg::result_t                first_word;

  assign wr_ptr_plus = wr_ptr + rlepe_pkg::QUEUE_IDX_W'(1);
  assign push_n      = {1'b0, push.first} + {1'b0, push.second};
  assign pop         = out_valid && !out_stall;
  assign first_word  = push.first ? res_a : res_b;

  assign space_ok  = (count <= SPACE_LIMIT);
  assign out_valid = (count != '0);
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + rlepe_pkg::QUEUE_IDX_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + rlepe_pkg::QUEUE_IDX_W'(1);
      end
      count <= count + rlepe_pkg::QUEUE_CNT_W'(push_n)
                     - rlepe_pkg::QUEUE_CNT_W'(pop);
    end
  end

  // Payload slots, no reset
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= first_word;
    end
    if (push.first && push.second) begin
      mem[wr_ptr_plus] <= res_b;
    end
  end

endmodule

// ===== hdl/rlepe_core.sv =====
// ----------------------------------------------------------------------------
// rlepe_core
// Input register, run state and pair/budget logic for one byte per cycle while the queue has room.
// ----------------------------------------------------------------------------
module rlepe_core #(
  parameter int unsigned BUFFER_BYTES = rlepe_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               end_of_input,
  input  logic               compress_wanted,
  input  logic [15:0]        min_raw_length,
  input  logic               space_ok,
  output rlepe_pkg::push_t   push,
  output rlepe_pkg::result_t res_a,
  output rlepe_pkg::result_t res_b
);

  localparam logic [16:0] BUF_LIMIT = 17'(BUFFER_BYTES);

  // Input register
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;
  logic       in_q_compress;

  // Message state
  logic [7:0]  cur_value;
  logic [7:0]  cur_count;
  logic        run_open;
  logic [15:0] raw_count;
  logic [8:0]  out_count;
  logic        overflow_seen;

  logic        process;
  logic        extend;
  logic [15:0] raw_len;
  logic        too_long;
  logic        emit1;
  logic [9:0]  next1;
  logic        fits1;
  logic [8:0]  out1;
  logic        ovf1;
  logic [7:0]  val2;
  logic [7:0]  cnt2;
  logic [9:0]  next2;
  logic        fits2;
  logic [8:0]  out2;
  logic        ovf2;
  logic        keep;

  assign process  = in_q_valid && space_ok;
  assign in_stall = in_q_valid && !space_ok;

  always_comb begin
    extend   = run_open && (in_q_byte == cur_value) && (cur_count != rlepe_pkg::RUN_MAX);
    raw_len  = (raw_count != rlepe_pkg::RAW_SAT) ? raw_count + 16'd1 : rlepe_pkg::RAW_SAT;
    too_long = {1'b0, raw_len} > BUF_LIMIT;

    // Close the open run when the byte breaks it or the run is full
    emit1 = run_open && !extend;
    next1 = {1'b0, out_count} + rlepe_pkg::PAIR_BYTES;
    fits1 = ({7'd0, next1} <= BUF_LIMIT) && (next1 <= rlepe_pkg::OUT_CAP);
    out1  = (emit1 && fits1) ? next1[8:0] : out_count;
    ovf1  = overflow_seen || (emit1 && !fits1);

    val2 = extend ? cur_value : in_q_byte;
    cnt2 = extend ? cur_count + 8'd1 : 8'd1;

    // Final pair on the last byte
    next2 = {1'b0, out1} + rlepe_pkg::PAIR_BYTES;
    fits2 = ({7'd0, next2} <= BUF_LIMIT) && (next2 <= rlepe_pkg::OUT_CAP);
    out2  = fits2 ? next2[8:0] : out1;
    ovf2  = ovf1 || !fits2;
    keep  = in_q_compress && !ovf2 && !too_long && (raw_len > min_raw_length)
            && ({7'd0, out2} < raw_len);

    res_a.run_length      = fits1 ? cur_count : 8'd0;
    res_a.run_value       = fits1 ? cur_value : 8'd0;
    res_a.pair_valid      = fits1;
    res_a.last_result     = 1'b0;
    res_a.encoded_length  = out1;
    res_a.budget_exceeded = ovf1;
    res_a.keep_encoded    = 1'b0;
    res_a.input_too_long  = too_long;

    res_b.run_length      = fits2 ? cnt2 : 8'd0;
    res_b.run_value       = fits2 ? val2 : 8'd0;
    res_b.pair_valid      = fits2;
    res_b.last_result     = 1'b1;
    res_b.encoded_length  = out2;
    res_b.budget_exceeded = ovf2;
    res_b.keep_encoded    = keep;
    res_b.input_too_long  = too_long;

    push.first  = process && emit1;
    push.second = process && in_q_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid    <= 1'b0;
      cur_value     <= '0;
      cur_count     <= '0;
      run_open      <= 1'b0;
      raw_count     <= '0;
      out_count     <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_q_valid <= 1'b1;
      end else if (process) begin
        in_q_valid <= 1'b0;
      end

      if (process) begin
        if (in_q_last) begin
          cur_value     <= '0;
          cur_count     <= '0;
          run_open      <= 1'b0;
          raw_count     <= '0;
          out_count     <= '0;
          overflow_seen <= 1'b0;
        end else begin
          cur_value     <= val2;
          cur_count     <= cnt2;
          run_open      <= 1'b1;
          raw_count     <= raw_len;
          out_count     <= out1;
          overflow_seen <= ovf1;
        end
      end
    end
  end

  // Payload of the input register, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_byte     <= data_byte;
      in_q_last     <= end_of_input;
      in_q_compress <= compress_wanted;
    end
  end

endmodule

// ===== hdl/rle_pair_encoder.sv =====
// ----------------------------------------------------------------------------
// rle_pair_encoder
// Run-length encoder emitting (count, value) pairs under an output budget.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle and groups equal bytes into runs of
// up to 255. Each closed run leaves as one result word carrying the pair;
// a pair that would push the encoded length past BUFFER_BYTES is dropped
// (count and value read zero, pair_valid low) and budget_exceeded stays set
// until the message ends. The byte flagged end_of_input closes the open run
// and yields the final word (last_result high) with the encoded length and
// the keep_encoded decision; when that byte also breaks a run, two words
// come out, the closed run first. A byte is registered on acceptance,
// worked once the result queue has room and its words land in that
// four-entry queue. Input runs at one byte per cycle while the queue
// has room for two words; the output side moves one word per cycle while
// out_stall is low. min_raw_length is written through the cfg channel,
// which is always ready; write it only while no message is in flight.
// ----------------------------------------------------------------------------
module rle_pair_encoder #(
  parameter int unsigned BUFFER_BYTES = rlepe_pkg::BUFFER_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,

  // Byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        end_of_input,
  input  logic        compress_wanted,

  // Result output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  run_length,
  output logic [7:0]  run_value,
  output logic        pair_valid,
  output logic        last_result,
  output logic [8:0]  encoded_length,
  output logic        budget_exceeded,
  output logic        keep_encoded,
  output logic        input_too_long
);

  logic [15:0]        min_raw_length;
  logic               space_ok;
  rlepe_pkg::push_t   push;
  rlepe_pkg::result_t res_a;
  rlepe_pkg::result_t res_b;
  rlepe_pkg::result_t out_word;

  // Config register: always accept the write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_raw_length <= rlepe_pkg::MIN_RAW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      min_raw_length <= cfg_data;
    end
  end

  // Run tracking and pair/budget decision
  rlepe_core #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .end_of_input    (end_of_input),
    .compress_wanted (compress_wanted),
    .min_raw_length  (min_raw_length),
    .space_ok        (space_ok),
    .push            (push),
    .res_a           (res_a),
    .res_b           (res_b)
  );

  // Hold finished words until the consumer takes them
  rlepe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res_a     (res_a),
    .res_b     (res_b),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  assign run_length      = out_word.run_length;
  assign run_value       = out_word.run_value;
  assign pair_valid      = out_word.pair_valid;
  assign last_result     = out_word.last_result;
  assign encoded_length  = out_word.encoded_length;
  assign budget_exceeded = out_word.budget_exceeded;
  assign keep_encoded    = out_word.keep_encoded;
  assign input_too_long  = out_word.input_too_long;

endmodule

// ===== hdl/rlepe_checker.sv =====
// ----------------------------------------------------------------------------
// rlepe_checker
// Port-level checks on the result words of the run-length pair encoder.
// ----------------------------------------------------------------------------
module rlepe_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] run_length,
  input logic [7:0] run_value,
  input logic       pair_valid,
  input logic       last_result,
  input logic [8:0] encoded_length,
  input logic       budget_exceeded,
  input logic       keep_encoded,
  input logic       input_too_long
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(run_length) && $stable(run_value)
      && $stable(encoded_length) && $stable(last_result))
    else $error("result word changed while stalled");

  // Keep only on a clean final pair
  a_keep_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && keep_encoded |-> last_result && pair_valid && !budget_exceeded
      && !input_too_long)
    else $error("keep_encoded on a word that cannot select encoded form");

  // Drop a pair only with overflow flagged and zeroed payload
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pair_valid |-> budget_exceeded && run_length == 8'd0
      && run_value == 8'd0)
    else $error("dropped pair without overflow or with payload");

  // Advance the length two bytes at a time
  a_len_even: assert property (@(posedge clk) disable iff (rst)
    out_valid && pair_valid |-> !encoded_length[0] && encoded_length != 9'd0
      && run_length != 8'd0)
    else $error("carried pair with bad length or count");

endmodule

bind rle_pair_encoder rlepe_checker u_checker (.*);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the run-length pair encoder.
// ----------------------------------------------------------------------------
// Bytes go in as messages, and every accepted word is checked against a
// behavioral encoder kept in step with the input. A short table of hand-made
// messages comes first: single bytes, run breaks on the last byte and
// min_raw_length at its extremes. Random messages follow. They are short and
// run-rich, budget-busting alternations and overlong messages with runs past
// the run limit. Both sides idle at random, except for one phase that runs
// flat out.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned BUDGET       = rlepe_pkg::BUFFER_BYTES_DEFAULT;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {SHAPE_SHORT, SHAPE_RUNS, SHAPE_ALTERNATE, SHAPE_LONG} shape_t;

  // One directed stimulus row; a fixed word overrides the predicted last word
  typedef struct packed {
    row_kind_t          kind;
    logic [15:0]        value;
    logic               eoi;
    logic               cw;
    logic               fixed;
    rlepe_pkg::result_t word;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_input;
  logic        compress_wanted;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  run_length;
  logic [7:0]  run_value;
  logic        pair_valid;
  logic        last_result;
  logic [8:0]  encoded_length;
  logic        budget_exceeded;
  logic        keep_encoded;
  logic        input_too_long;

  // Travels with the byte so the checker knows which words are typed in
  logic               stim_fixed;
  rlepe_pkg::result_t stim_word;

  // Encoder state as predicted
  logic [15:0] min_raw     = rlepe_pkg::MIN_RAW_RESET;
  logic [7:0]  run_byte    = '0;
  logic [7:0]  run_len     = '0;
  logic        run_live    = 1'b0;
  logic [15:0] raw_seen    = '0;
  int unsigned enc_bytes   = 0;
  logic        budget_hit  = 1'b0;

  rlepe_pkg::result_t due_words[$];
  row_t        rows[$];
  int unsigned mismatches  = 0;
  int unsigned sent_items  = 0;
  int unsigned quiet_cycles = 0;
  logic        moved;
  bit          sender_idle   = 1'b1;
  bit          receiver_idle = 1'b1;

  rle_pair_encoder #(
    .BUFFER_BYTES(BUDGET)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_input   (end_of_input),
    .compress_wanted(compress_wanted),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .run_length     (run_length),
    .run_value      (run_value),
    .pair_valid     (pair_valid),
    .last_result    (last_result),
    .encoded_length (encoded_length),
    .budget_exceeded(budget_exceeded),
    .keep_encoded   (keep_encoded),
    .input_too_long (input_too_long)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
  endtask

  // Close the open run into a word; drop the pair if it would bust the budget
  task automatic close_run(input logic last, input logic cw, input int unsigned raw_len);
    rlepe_pkg::result_t w;
    int unsigned        next;
    logic               fits;
    logic               too_long;
    next     = enc_bytes + rlepe_pkg::PAIR_BYTES;
    fits     = (next <= BUDGET) && (next <= rlepe_pkg::OUT_CAP);
    too_long = raw_len > BUDGET;
    if (fits) begin
      enc_bytes = next;
    end else begin
      budget_hit = 1'b1;
    end
    w.run_length      = fits ? run_len : 8'd0;
    w.run_value       = fits ? run_byte : 8'd0;
    w.pair_valid      = fits;
    w.last_result     = last;
    w.encoded_length  = enc_bytes[8:0];
    w.budget_exceeded = budget_hit;
    w.keep_encoded    = last && cw && !budget_hit && !too_long &&
                        (raw_len > min_raw) && (enc_bytes < raw_len);
    w.input_too_long  = too_long;
    due_words.push_back(w);
  endtask

  // Advance the encoder by one byte and queue the words it yields
  task automatic encode_step(input logic [7:0] b, input logic last, input logic cw);
    int unsigned raw_len;
    raw_len = (raw_seen < rlepe_pkg::RAW_SAT) ? raw_seen + 1 : rlepe_pkg::RAW_SAT;
    if (run_live && b == run_byte && run_len < rlepe_pkg::RUN_MAX) begin
      run_len++;
    end else begin
      if (run_live) close_run(1'b0, cw, raw_len);
      run_byte = b;
      run_len  = 8'd1;
      run_live = 1'b1;
    end
    raw_seen = 16'(raw_len);
    if (last) begin
      close_run(1'b1, cw, raw_len);
      run_byte   = '0;
      run_len    = '0;
      run_live   = 1'b0;
      raw_seen   = '0;
      enc_bytes  = 0;
      budget_hit = 1'b0;
    end
  endtask

  task automatic check_word(input rlepe_pkg::result_t got);
    rlepe_pkg::result_t want;
    if (due_words.size() == 0) begin
      report_mismatch("word with nothing due", 1, 0);
      return;
    end
    want = due_words.pop_front();
    if (got.run_length != want.run_length)
      report_mismatch("run_length", got.run_length, want.run_length);
    if (got.run_value != want.run_value)
      report_mismatch("run_value", got.run_value, want.run_value);
    if (got.pair_valid != want.pair_valid)
      report_mismatch("pair_valid", got.pair_valid, want.pair_valid);
    if (got.last_result != want.last_result)
      report_mismatch("last_result", got.last_result, want.last_result);
    if (got.encoded_length != want.encoded_length)
      report_mismatch("encoded_length", got.encoded_length, want.encoded_length);
    if (got.budget_exceeded != want.budget_exceeded)
      report_mismatch("budget_exceeded", got.budget_exceeded, want.budget_exceeded);
    if (got.keep_encoded != want.keep_encoded)
      report_mismatch("keep_encoded", got.keep_encoded, want.keep_encoded);
    if (got.input_too_long != want.input_too_long)
      report_mismatch("input_too_long", got.input_too_long, want.input_too_long);
  endtask

  // Track every handshake at the edge: register writes, bytes in, words out.
  // A long stretch with no handshake at all means the block hung.
  always @(posedge clk) begin
    if (!rst) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready === 1'b1) begin
        min_raw = cfg_data;
        moved   = 1'b1;
      end
      if (in_valid && in_stall === 1'b0) begin
        encode_step(data_byte, end_of_input, compress_wanted);
        if (stim_fixed) due_words[due_words.size() - 1] = stim_word;
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        check_word({run_length, run_value, pair_valid, last_result, encoded_length,
                    budget_exceeded, keep_encoded, input_too_long});
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Receiver: while receiver_idle is set, hold off for a random stretch before taking each word
  initial begin
    int unsigned hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      hold = receiver_idle ? $urandom_range(0, 15) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1 || out_stall);
    end
  end

  // Offer one byte, after a random gap while sender_idle is set, and hold it until it is taken
  task automatic send_word(input logic [7:0] b, input logic eoi, input logic cw,
                           input logic fix, input rlepe_pkg::result_t w);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    data_byte       <= b;
    end_of_input    <= eoi;
    compress_wanted <= cw;
    stim_fixed      <= fix;
    stim_word       <= w;
    do @(posedge clk); while (in_stall !== 1'b0);
    sent_items++;
  endtask

  // Drop valid and wait until every word due has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  // Write the register only once the block is quiet
  task automatic write_min_raw(input logic [15:0] v);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [15:0] value, input logic eoi,
                         input logic cw, input logic fix, input rlepe_pkg::result_t w);
    row_t r;
    r.kind  = kind;
    r.value = value;
    r.eoi   = eoi;
    r.cw    = cw;
    r.fixed = fix;
    r.word  = w;
    rows.push_back(r);
  endtask

  // Final word of a message whose whole encoded form is one fitting pair
  function automatic rlepe_pkg::result_t end_word(input logic [7:0] cnt,
                                                  input logic [7:0] val,
                                                  input logic keep);
    end_word = {cnt, val, 1'b1, 1'b1, 9'd2, 1'b0, keep, 1'b0};
  endfunction

  // Build a message out of runs of distinct neighbors and send it
  task automatic send_message(input shape_t shape);
    logic [7:0]  body[$];
    logic [7:0]  v;
    logic        last;
    int unsigned len;
    int unsigned run;
    int unsigned max_run;
    v = 8'($urandom_range(0, 255));
    case (shape)
      SHAPE_SHORT: begin
        len = $urandom_range(1, 8);
        max_run = 3;
      end
      SHAPE_RUNS: begin
        len = $urandom_range(10, 90);
        max_run = 20;
      end
      SHAPE_ALTERNATE: begin
        // more pairs than the budget holds
        len = $urandom_range(129, 140);
        max_run = 1;
      end
      default: begin
        // past the buffer size, opening with a run longer than one pair carries
        len = $urandom_range(257, 290);
        max_run = 10;
        repeat ($urandom_range(256, 270)) body.push_back(v);
      end
    endcase
    while (body.size() < len) begin
      v = v + 8'($urandom_range(1, 255));
      run = $urandom_range(1, max_run);
      while (run != 0 && body.size() < len) begin
        body.push_back(v);
        run--;
      end
    end
    foreach (body[i]) begin
      if ($urandom_range(0, 49) == 0) drain_results();
      last = (i == body.size() - 1);
      send_word(body[i], last, last ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1)),
                1'b0, '0);
    end
  endtask

  initial begin
    int unsigned phase_start;
    logic [15:0] phase_min;
    rst             <= 1'b1;
    cfg_valid       <= 1'b0;
    cfg_data        <= '0;
    in_valid        <= 1'b0;
    data_byte       <= '0;
    end_of_input    <= 1'b0;
    compress_wanted <= 1'b0;
    stim_fixed      <= 1'b0;
    stim_word       <= '0;

    // Directed messages; min_raw_length starts at its reset value
    add_row(ROW_BYTE, 16'h00, 1'b1, 1'b1, 1'b1, end_word(8'd1, 8'h00, 1'b0));
    add_row(ROW_BYTE, 16'hFF, 1'b1, 1'b0, 1'b1, end_word(8'd1, 8'hFF, 1'b0));
    // run broken by the last byte: closed run, then the one-byte run
    add_row(ROW_BYTE, 16'hAA, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'hAA, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'h55, 1'b1, 1'b1, 1'b0, '0);
    add_row(ROW_CFG, 16'h0000, 1'b0, 1'b0, 1'b0, '0);
    // run extended through the last byte; encoded form is shorter, keep it
    add_row(ROW_BYTE, 16'h3C, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'h3C, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'h3C, 1'b1, 1'b1, 1'b1, end_word(8'd3, 8'h3C, 1'b1));
    add_row(ROW_BYTE, 16'h01, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'h02, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'h80, 1'b1, 1'b1, 1'b0, '0);
    add_row(ROW_CFG, 16'hFFFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'h7E, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'h7E, 1'b1, 1'b1, 1'b1, end_word(8'd2, 8'h7E, 1'b0));
    add_row(ROW_CFG, 16'h0002, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'h11, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'h11, 1'b0, 1'b1, 1'b0, '0);
    add_row(ROW_BYTE, 16'h11, 1'b1, 1'b0, 1'b1, end_word(8'd3, 8'h11, 1'b0));
    add_row(ROW_BYTE, 16'hEE, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'hEE, 1'b0, 1'b0, 1'b0, '0);
    add_row(ROW_BYTE, 16'hEE, 1'b1, 1'b1, 1'b1, end_word(8'd3, 8'hEE, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_min_raw(rows[i].value);
      end else begin
        send_word(rows[i].value[7:0], rows[i].eoi, rows[i].cw, rows[i].fixed, rows[i].word);
      end
    end

    // Random phases, each under its own threshold; phase 1 never idles
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: phase_min = 16'd0;
        1: phase_min = 16'($urandom_range(8, 80));
        2: phase_min = rlepe_pkg::MIN_RAW_RESET;
        default: phase_min = 16'($urandom_range(1, 150));
      endcase
      write_min_raw(phase_min);
      phase_start = sent_items;
      if (ph == 0) send_message(SHAPE_ALTERNATE);
      if (ph == 2) send_message(SHAPE_LONG);
      while (sent_items - phase_start < PHASE_ITEMS) begin
        sender_idle   = (ph != 1) && ($urandom_range(0, 5) != 0);
        receiver_idle = (ph != 1) && ($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 7) == 0) drain_results();
        send_message(($urandom_range(0, 2) != 0) ? SHAPE_SHORT : SHAPE_RUNS);
      end
    end

    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
